>>> src/brmsu_pkg.sv
// ----------------------------------------------------------------------------
// brmsu_pkg
// Types and constants for the banked rom mapper with sram unlock: request and
// response words, command codes, register offsets and the unlock bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package brmsu_pkg;

    // battery sram geometry
    localparam int unsigned SRAM_BYTES = 8192;
    localparam int unsigned SRAM_AW    = $clog2(SRAM_BYTES);
    localparam logic [SRAM_AW-1:0] SRAM_LAST = SRAM_AW'(SRAM_BYTES - 1);

    // command codes
    localparam logic [1:0] CMD_MEM_WRITE = 2'd0;
    localparam logic [1:0] CMD_MEM_READ  = 2'd1;
    localparam logic [1:0] CMD_IO_WRITE  = 2'd2;

    // register offsets in the 16 KB window
    localparam logic [13:0] OFS_UNLOCK_LOW  = 14'h1FFE;
    localparam logic [13:0] OFS_UNLOCK_HIGH = 14'h1FFF;
    localparam logic [13:0] OFS_FM_ADDR     = 14'h3FF4;
    localparam logic [13:0] OFS_FM_DATA     = 14'h3FF5;
    localparam logic [13:0] OFS_SOUND_CTRL  = 14'h3FF6;
    localparam logic [13:0] OFS_BANK        = 14'h3FF7;

    // unlock sequence and register masks
    localparam logic [7:0] UNLOCK_LOW_KEY  = 8'h4D;
    localparam logic [7:0] UNLOCK_HIGH_KEY = 8'h69;
    localparam logic [7:0] SOUND_CTRL_MASK = 8'h11;
    localparam logic [7:0] ERASED_BYTE     = 8'hFF;

    // request word
    typedef struct packed {
        logic [1:0]  cmd;
        logic [13:0] address;
        logic [7:0]  wdata;
    } req_t;

    // response word
    typedef struct packed {
        logic [7:0]  read_data;
        logic        from_rom;
        logic [15:0] rom_address;
        logic        fm_write;
        logic        fm_is_data;
        logic [7:0]  fm_byte;
    } rsp_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } state_t;

endpackage

`default_nettype wire

>>> src/banked_rom_mapper_with_sram_unlock_unit.sv
// ----------------------------------------------------------------------------
// banked_rom_mapper_with_sram_unlock_unit
// Cartridge mapper: bank register, unlock bytes, sound control and an 8 KB
// battery sram, answering one cpu bus word with one response word.
// ----------------------------------------------------------------------------
`default_nettype none

// After reset the block sweeps the 8 KB battery sram to 0xFF, one byte a
// cycle, and holds req_stall high until the sweep is done; configuration writes
// are taken at any time. Afterwards a word is accepted whenever no sram read is
// in flight and the response register is empty or draining. Writes, io writes,
// rom-mode reads and reads of the upper half in sram mode go straight into the
// response register; an sram read passes the sram read register and the ST_READ
// state first. The response sits in an output register until taken.
module banked_rom_mapper_with_sram_unlock_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    // request channel
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire brmsu_pkg::req_t req,
    // response channel
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output brmsu_pkg::rsp_t      rsp,
    // configuration channel
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic            cfg_data
);

    localparam int unsigned AW = brmsu_pkg::SRAM_AW;

    // battery sram
    logic [7:0] sram [brmsu_pkg::SRAM_BYTES];
    logic [7:0] sram_rdata_reg;

    brmsu_pkg::state_t state_reg, state_next;

    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [7:0]    unlock_low_reg, unlock_low_next;
    logic [7:0]    unlock_high_reg, unlock_high_next;
    logic          sram_mode_reg, sram_mode_next;
    logic [7:0]    sound_ctrl_reg, sound_ctrl_next;
    logic [1:0]    bank_num_reg, bank_num_next;
    logic [7:0]    bank_byte_reg, bank_byte_next;
    logic          present_reg;

    logic              rsp_valid_reg, rsp_valid_next;
    brmsu_pkg::rsp_t   rsp_reg, rsp_next;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    logic out_free;
    logic req_fire;
    logic fm_gate;

    // handshake
    assign cfg_ready = 1'b1;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == brmsu_pkg::ST_IDLE) && out_free);
    assign req_fire  = req_valid && !req_stall;
    assign fm_gate   = present_reg && sound_ctrl_reg[0];
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brmsu_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state, register updates and memory port control
    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        unlock_low_next  = unlock_low_reg;
        unlock_high_next = unlock_high_reg;
        sram_mode_next   = sram_mode_reg;
        sound_ctrl_next  = sound_ctrl_reg;
        bank_num_next    = bank_num_reg;
        bank_byte_next   = bank_byte_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        rsp_next         = rsp_reg;
        mem_we           = 1'b0;
        mem_waddr        = req.address[AW-1:0];
        mem_wdata        = req.wdata;
        mem_re           = 1'b0;
        mem_raddr        = req.address[AW-1:0];

        unique case (state_reg)
            brmsu_pkg::ST_CLEAR:
            begin
                // erase sweep after reset
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = brmsu_pkg::ERASED_BYTE;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == brmsu_pkg::SRAM_LAST)
                begin
                    state_next = brmsu_pkg::ST_IDLE;
                end
            end

            brmsu_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    rsp_next       = '0;
                    rsp_valid_next = 1'b1;
                    case (req.cmd)
                        brmsu_pkg::CMD_MEM_WRITE:
                        begin
                            if (req.address == brmsu_pkg::OFS_UNLOCK_LOW)
                            begin
                                mem_we          = 1'b1;
                                unlock_low_next = req.wdata;
                                sram_mode_next  =
                                    (req.wdata == brmsu_pkg::UNLOCK_LOW_KEY) &&
                                    (unlock_high_reg == brmsu_pkg::UNLOCK_HIGH_KEY);
                            end
                            else if (req.address == brmsu_pkg::OFS_UNLOCK_HIGH)
                            begin
                                mem_we           = 1'b1;
                                unlock_high_next = req.wdata;
                                sram_mode_next   =
                                    (unlock_low_reg == brmsu_pkg::UNLOCK_LOW_KEY) &&
                                    (req.wdata == brmsu_pkg::UNLOCK_HIGH_KEY);
                            end
                            else if (req.address == brmsu_pkg::OFS_FM_ADDR ||
                                     req.address == brmsu_pkg::OFS_FM_DATA)
                            begin
                                if (fm_gate)
                                begin
                                    rsp_next.fm_write   = 1'b1;
                                    rsp_next.fm_is_data = req.address[0];
                                    rsp_next.fm_byte    = req.wdata;
                                end
                            end
                            else if (req.address == brmsu_pkg::OFS_SOUND_CTRL)
                            begin
                                sound_ctrl_next = req.wdata & brmsu_pkg::SOUND_CTRL_MASK;
                            end
                            else if (req.address == brmsu_pkg::OFS_BANK)
                            begin
                                if (req.wdata[1:0] != bank_num_reg)
                                begin
                                    bank_num_next  = req.wdata[1:0];
                                    bank_byte_next = req.wdata;
                                end
                            end
                            else if (sram_mode_reg &&
                                     (req.address < brmsu_pkg::OFS_UNLOCK_LOW))
                            begin
                                mem_we = 1'b1;
                            end
                        end

                        brmsu_pkg::CMD_MEM_READ:
                        begin
                            if (sram_mode_reg)
                            begin
                                if (!req.address[13])
                                begin
                                    // data arrives next cycle
                                    mem_re         = 1'b1;
                                    rsp_valid_next = 1'b0;
                                    state_next     = brmsu_pkg::ST_READ;
                                end
                                else
                                begin
                                    rsp_next.read_data = brmsu_pkg::ERASED_BYTE;
                                end
                            end
                            else if (req.address == brmsu_pkg::OFS_UNLOCK_LOW)
                            begin
                                rsp_next.read_data = unlock_low_reg;
                            end
                            else if (req.address == brmsu_pkg::OFS_UNLOCK_HIGH)
                            begin
                                rsp_next.read_data = unlock_high_reg;
                            end
                            else if (req.address == brmsu_pkg::OFS_SOUND_CTRL)
                            begin
                                rsp_next.read_data = sound_ctrl_reg;
                            end
                            else if (req.address == brmsu_pkg::OFS_BANK)
                            begin
                                rsp_next.read_data = bank_byte_reg;
                            end
                            else
                            begin
                                rsp_next.from_rom    = 1'b1;
                                rsp_next.rom_address = {bank_num_reg, req.address};
                            end
                        end

                        brmsu_pkg::CMD_IO_WRITE:
                        begin
                            if (fm_gate)
                            begin
                                rsp_next.fm_write   = 1'b1;
                                rsp_next.fm_is_data = req.address[0];
                                rsp_next.fm_byte    = req.wdata;
                            end
                        end

                        default:
                        begin
                            // unused command gives an all-zero word
                        end
                    endcase
                end
            end

            brmsu_pkg::ST_READ:
            begin
                // capture sram data into the response register
                rsp_next           = '0;
                rsp_next.read_data = sram_rdata_reg;
                rsp_valid_next     = 1'b1;
                state_next         = brmsu_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = brmsu_pkg::ST_CLEAR;
            end
        endcase
    end

    // control and mapper registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg    <= '0;
            unlock_low_reg  <= brmsu_pkg::ERASED_BYTE;
            unlock_high_reg <= brmsu_pkg::ERASED_BYTE;
            sram_mode_reg   <= 1'b0;
            sound_ctrl_reg  <= '0;
            bank_num_reg    <= '0;
            bank_byte_reg   <= '0;
            present_reg     <= 1'b1;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            clr_addr_reg    <= clr_addr_next;
            unlock_low_reg  <= unlock_low_next;
            unlock_high_reg <= unlock_high_next;
            sram_mode_reg   <= sram_mode_next;
            sound_ctrl_reg  <= sound_ctrl_next;
            bank_num_reg    <= bank_num_next;
            bank_byte_reg   <= bank_byte_next;
            rsp_valid_reg   <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                present_reg <= cfg_data;
            end
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // sram write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sram[mem_waddr] <= mem_wdata;
        end
    end

    // sram read port
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            sram_rdata_reg <= sram[mem_raddr];
        end
    end

endmodule

`default_nettype wire

>>> test/mapper_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mapper_checker
// Watches the request, response and configuration channels of the cartridge
// mapper, keeps its own image of the mapper state, predicts one response word
// per accepted request word and compares the words in order, field by field.
// ----------------------------------------------------------------------------

module mapper_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_stall,
    input  brmsu_pkg::req_t req,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  brmsu_pkg::rsp_t rsp,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  logic            cfg_data,
    output int              fail_count,
    output int              pending,
    output int              words_checked,
    output int              sram_reads,
    output int              sound_writes
);

    // mirrored mapper state
    logic [7:0] sram_img [brmsu_pkg::SRAM_BYTES];
    logic [7:0] key_low;
    logic [7:0] key_high;
    logic       sram_on;
    logic [7:0] snd_ctrl;
    logic [1:0] bank_sel;
    logic [7:0] bank_byte;
    logic       chip_present;

    // response words owed by the mapper, oldest first
    brmsu_pkg::rsp_t awaited_rsp [$];
    brmsu_pkg::rsp_t want;

    // one line per mismatch, printing stops after a while but counting goes on
    task automatic report(string what, logic [15:0] got, logic [15:0] exp_val);
        fail_count++;
        if (fail_count <= 30)
            $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
    endtask

    task automatic check_word(brmsu_pkg::rsp_t got, brmsu_pkg::rsp_t exp_word);
        if (got.read_data !== exp_word.read_data)
            report("read_data", 16'(got.read_data), 16'(exp_word.read_data));
        if (got.from_rom !== exp_word.from_rom)
            report("from_rom", 16'(got.from_rom), 16'(exp_word.from_rom));
        if (got.rom_address !== exp_word.rom_address)
            report("rom_address", got.rom_address, exp_word.rom_address);
        if (got.fm_write !== exp_word.fm_write)
            report("fm_write", 16'(got.fm_write), 16'(exp_word.fm_write));
        if (got.fm_is_data !== exp_word.fm_is_data)
            report("fm_is_data", 16'(got.fm_is_data), 16'(exp_word.fm_is_data));
        if (got.fm_byte !== exp_word.fm_byte)
            report("fm_byte", 16'(got.fm_byte), 16'(exp_word.fm_byte));
    endtask

    // sound chip write, passed only when the chip is there and enabled
    function automatic brmsu_pkg::rsp_t sound_word(logic port, logic [7:0] value);
        brmsu_pkg::rsp_t r;
        r = '0;
        if (chip_present && snd_ctrl[0])
        begin
            r.fm_write   = 1'b1;
            r.fm_is_data = port;
            r.fm_byte    = value;
            sound_writes++;
        end
        return r;
    endfunction

    // apply one bus word to the mirrored state and return its answer
    function automatic brmsu_pkg::rsp_t map_access(brmsu_pkg::req_t w);
        brmsu_pkg::rsp_t r;
        r = '0;
        case (w.cmd)
            brmsu_pkg::CMD_MEM_WRITE:
            begin
                if (w.address == brmsu_pkg::OFS_UNLOCK_LOW ||
                    w.address == brmsu_pkg::OFS_UNLOCK_HIGH)
                begin
                    // unlock bytes land in sram too, whatever the mode
                    sram_img[w.address[brmsu_pkg::SRAM_AW-1:0]] = w.wdata;
                    if (w.address[0])
                        key_high = w.wdata;
                    else
                        key_low = w.wdata;
                    sram_on = (key_low == brmsu_pkg::UNLOCK_LOW_KEY) &&
                              (key_high == brmsu_pkg::UNLOCK_HIGH_KEY);
                end
                else if (w.address == brmsu_pkg::OFS_FM_ADDR ||
                         w.address == brmsu_pkg::OFS_FM_DATA)
                    r = sound_word(w.address[0], w.wdata);
                else if (w.address == brmsu_pkg::OFS_SOUND_CTRL)
                    snd_ctrl = w.wdata & brmsu_pkg::SOUND_CTRL_MASK;
                else if (w.address == brmsu_pkg::OFS_BANK)
                begin
                    // the register only follows a change of bank
                    if (w.wdata[1:0] != bank_sel)
                    begin
                        bank_sel  = w.wdata[1:0];
                        bank_byte = w.wdata;
                    end
                end
                else if (sram_on && w.address < brmsu_pkg::OFS_UNLOCK_LOW)
                    sram_img[w.address[brmsu_pkg::SRAM_AW-1:0]] = w.wdata;
            end
            brmsu_pkg::CMD_MEM_READ:
            begin
                if (sram_on)
                begin
                    // lower 8 KB is sram, upper half reads erased
                    r.read_data = w.address[13] ? brmsu_pkg::ERASED_BYTE :
                                  sram_img[w.address[brmsu_pkg::SRAM_AW-1:0]];
                    sram_reads++;
                end
                else if (w.address == brmsu_pkg::OFS_UNLOCK_LOW)
                    r.read_data = key_low;
                else if (w.address == brmsu_pkg::OFS_UNLOCK_HIGH)
                    r.read_data = key_high;
                else if (w.address == brmsu_pkg::OFS_SOUND_CTRL)
                    r.read_data = snd_ctrl;
                else if (w.address == brmsu_pkg::OFS_BANK)
                    r.read_data = bank_byte;
                else
                begin
                    r.from_rom    = 1'b1;
                    r.rom_address = {bank_sel, w.address};
                end
            end
            brmsu_pkg::CMD_IO_WRITE:
                r = sound_word(w.address[0], w.wdata);
            default:
                ;
        endcase
        return r;
    endfunction

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < brmsu_pkg::SRAM_BYTES; i++)
                sram_img[i] = brmsu_pkg::ERASED_BYTE;
            key_low       = brmsu_pkg::ERASED_BYTE;
            key_high      = brmsu_pkg::ERASED_BYTE;
            sram_on       = 1'b0;
            snd_ctrl      = '0;
            bank_sel      = '0;
            bank_byte     = '0;
            chip_present  = 1'b1;
            awaited_rsp.delete();
            fail_count    = 0;
            pending       = 0;
            words_checked = 0;
            sram_reads    = 0;
            sound_writes  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                chip_present = cfg_data;
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsp.size() == 0)
                    report("unexpected response word", 16'(rsp.read_data), 16'h0);
                else
                begin
                    want = awaited_rsp.pop_front();
                    check_word(rsp, want);
                    words_checked++;
                end
            end
            if (req_valid && !req_stall)
                awaited_rsp.push_back(map_access(req));
            pending = awaited_rsp.size();
        end
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the cartridge mapper with a directed opening and then random bus
// traffic built around unlock sequences, register and sound port access and
// raw noise, under both settings of the sound chip enable, with random idling
// on both channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module testbench;

    // unused command code, answered with an all-zero word
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int PHASES    = 6;
    localparam int PER_PHASE = 258;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            req_valid = 1'b0;
    logic            rsp_stall = 1'b0;
    logic            cfg_valid = 1'b0;
    logic            cfg_data  = 1'b0;
    brmsu_pkg::req_t req       = '0;
    logic            req_stall;
    logic            rsp_valid;
    logic            cfg_ready;
    brmsu_pkg::rsp_t rsp;

    int   fail_count;
    int   pending;
    int   words_checked;
    int   sram_reads;
    int   sound_writes;
    int   sent = 0;
    bit   calm = 1'b0;

    banked_rom_mapper_with_sram_unlock_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    mapper_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked),
        .sram_reads    (sram_reads),
        .sound_writes  (sound_writes)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // idle cycles before a word, none during calm stretches
    function automatic int idle_cycles();
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    // one request word, entered and left at a falling edge
    task automatic send_word(logic [1:0] c, logic [13:0] a, logic [7:0] d);
        int gap;
        if (sent % 48 == 0)
            calm = ($urandom_range(0, 3) == 0);
        gap = idle_cycles();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{cmd: c, address: a, wdata: d};
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
        sent++;
    endtask

    task automatic set_chip(logic on);
        cfg_valid <= 1'b1;
        cfg_data  <= on;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // let every owed response word come back
    task automatic drain();
        req_valid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
    endtask

    // response side stall pattern
    initial
    begin
        int n;
        forever
        begin
            n = idle_cycles();
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
            @(negedge clk);
        end
    end

    // edges of the fields, every command and the unlock corner cases
    task automatic directed_words();
        send_word(brmsu_pkg::CMD_MEM_READ,  14'h0000, 8'h00);
        send_word(brmsu_pkg::CMD_MEM_READ,  14'h3FFF, 8'hFF);
        send_word(brmsu_pkg::CMD_MEM_READ,  brmsu_pkg::OFS_UNLOCK_LOW, 8'h00);
        send_word(brmsu_pkg::CMD_MEM_READ,  brmsu_pkg::OFS_BANK, 8'h00);
        send_word(brmsu_pkg::CMD_MEM_WRITE, brmsu_pkg::OFS_SOUND_CTRL, 8'hFF);
        send_word(brmsu_pkg::CMD_MEM_READ,  brmsu_pkg::OFS_SOUND_CTRL, 8'h00);
        send_word(brmsu_pkg::CMD_IO_WRITE,  14'h0000, 8'h00);
        send_word(brmsu_pkg::CMD_IO_WRITE,  14'h3FFF, 8'hFF);
        send_word(brmsu_pkg::CMD_MEM_WRITE, brmsu_pkg::OFS_FM_ADDR, 8'h5A);
        send_word(brmsu_pkg::CMD_MEM_WRITE, brmsu_pkg::OFS_FM_DATA, 8'hA5);
        send_word(brmsu_pkg::CMD_MEM_WRITE, brmsu_pkg::OFS_BANK, 8'hFF);
        send_word(brmsu_pkg::CMD_MEM_READ,  14'h3FFF, 8'h00);
        // same bank again leaves the register alone
        send_word(brmsu_pkg::CMD_MEM_WRITE, brmsu_pkg::OFS_BANK, 8'h03);
        send_word(brmsu_pkg::CMD_MEM_READ,  brmsu_pkg::OFS_BANK, 8'h00);
        send_word(CMD_SPARE,                14'h3FFF, 8'hFF);
        // sram write while locked is dropped
        send_word(brmsu_pkg::CMD_MEM_WRITE, 14'h0000, 8'h00);
        send_word(brmsu_pkg::CMD_MEM_WRITE, brmsu_pkg::OFS_UNLOCK_LOW,
                  brmsu_pkg::UNLOCK_LOW_KEY);
        send_word(brmsu_pkg::CMD_MEM_WRITE, brmsu_pkg::OFS_UNLOCK_HIGH,
                  brmsu_pkg::UNLOCK_HIGH_KEY);
        send_word(brmsu_pkg::CMD_MEM_WRITE, 14'h0000, 8'hA5);
        send_word(brmsu_pkg::CMD_MEM_READ,  14'h0000, 8'h00);
        send_word(brmsu_pkg::CMD_MEM_READ,  brmsu_pkg::OFS_UNLOCK_HIGH, 8'h00);
        send_word(brmsu_pkg::CMD_MEM_READ,  14'h2000, 8'h00);
        // sound gate closed by control bit 0
        send_word(brmsu_pkg::CMD_MEM_WRITE, brmsu_pkg::OFS_SOUND_CTRL, 8'h10);
        send_word(brmsu_pkg::CMD_IO_WRITE,  14'h0001, 8'h77);
        send_word(brmsu_pkg::CMD_MEM_WRITE, brmsu_pkg::OFS_UNLOCK_HIGH, 8'h00);
    endtask

    // one access inside the unlocked window, mostly to a few hot offsets
    task automatic sram_access();
        int          k;
        logic [13:0] a;
        k = $urandom_range(0, 9);
        case ($urandom_range(0, 2))
            0:       a = 14'($urandom_range(0, 15));
            1:       a = 14'h1FF0 + 14'($urandom_range(0, 13));
            default: a = 14'($urandom_range(0, 14'h1FFF));
        endcase
        if (k < 4)
            send_word(brmsu_pkg::CMD_MEM_WRITE, a, 8'($urandom));
        else if (k < 8)
            send_word(brmsu_pkg::CMD_MEM_READ, a, 8'($urandom));
        else if (k == 8)
            send_word(brmsu_pkg::CMD_MEM_READ, 14'($urandom_range(14'h2000, 14'h3FFF)),
                      8'($urandom));
        else
            send_word(brmsu_pkg::CMD_IO_WRITE, 14'($urandom), 8'($urandom));
    endtask

    // unlock, work in sram, maybe lock again; now and then the keys are wrong
    task automatic unlock_run();
        bit broken;
        bit which;
        broken = ($urandom_range(0, 4) == 0);
        which  = 1'($urandom);
        send_word(brmsu_pkg::CMD_MEM_WRITE, brmsu_pkg::OFS_UNLOCK_LOW,
                  (broken && which) ? 8'($urandom) : brmsu_pkg::UNLOCK_LOW_KEY);
        send_word(brmsu_pkg::CMD_MEM_WRITE, brmsu_pkg::OFS_UNLOCK_HIGH,
                  (broken && !which) ? 8'($urandom) : brmsu_pkg::UNLOCK_HIGH_KEY);
        repeat ($urandom_range(4, 20))
            sram_access();
        if ($urandom_range(0, 1))
            send_word(brmsu_pkg::CMD_MEM_WRITE,
                      $urandom_range(0, 1) ? brmsu_pkg::OFS_UNLOCK_LOW :
                                             brmsu_pkg::OFS_UNLOCK_HIGH,
                      8'($urandom));
    endtask

    // register, sound port and rom traffic
    task automatic register_run();
        repeat ($urandom_range(2, 8))
        begin
            case ($urandom_range(0, 6))
                0: send_word(brmsu_pkg::CMD_MEM_WRITE, brmsu_pkg::OFS_SOUND_CTRL,
                             8'($urandom));
                1: send_word(brmsu_pkg::CMD_MEM_WRITE, brmsu_pkg::OFS_BANK, 8'($urandom));
                2: send_word(brmsu_pkg::CMD_IO_WRITE, 14'($urandom), 8'($urandom));
                3: send_word(brmsu_pkg::CMD_MEM_WRITE,
                             $urandom_range(0, 1) ? brmsu_pkg::OFS_FM_ADDR :
                                                    brmsu_pkg::OFS_FM_DATA,
                             8'($urandom));
                4:
                begin
                    case ($urandom_range(0, 3))
                        0:       send_word(brmsu_pkg::CMD_MEM_READ,
                                           brmsu_pkg::OFS_UNLOCK_LOW, 8'($urandom));
                        1:       send_word(brmsu_pkg::CMD_MEM_READ,
                                           brmsu_pkg::OFS_UNLOCK_HIGH, 8'($urandom));
                        2:       send_word(brmsu_pkg::CMD_MEM_READ,
                                           brmsu_pkg::OFS_SOUND_CTRL, 8'($urandom));
                        default: send_word(brmsu_pkg::CMD_MEM_READ,
                                           brmsu_pkg::OFS_BANK, 8'($urandom));
                    endcase
                end
                default: send_word(brmsu_pkg::CMD_MEM_READ, 14'($urandom), 8'($urandom));
            endcase
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int target;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_chip(1'b1);
        directed_words();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            set_chip(phase % 2 == 1);
            target = sent + PER_PHASE;
            while (sent < target)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: unlock_run();
                    4, 5, 6:    register_run();
                    default:
                        repeat ($urandom_range(1, 6))
                            send_word(2'($urandom), 14'($urandom), 8'($urandom));
                endcase
            end
        end
        drain();
        repeat (8) @(posedge clk);
        $display("checked %0d response words (%0d sram reads, %0d sound writes)",
                 words_checked, sram_reads, sound_writes);
        $display("sound chip enable switched over %0d phases, idling on both sides", PHASES);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("timeout with %0d response words outstanding", pending);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
src/brmsu_pkg.sv
src/banked_rom_mapper_with_sram_unlock_unit.sv
test/mapper_checker.sv
test/testbench.sv
